@@ src/interval_set_insert_lookup_assert.svh @@
// assertion macros shared by the interval set checker
`ifndef INTERVAL_SET_INSERT_LOOKUP_ASSERT_SVH
`define INTERVAL_SET_INSERT_LOOKUP_ASSERT_SVH

// checked property with reset disable
`define ISIL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("interval set check failed");

// checked property that also holds through reset
`define ISIL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("interval set check failed");

`endif

@@ src/isil_pkg.sv @@
// package: request and response types and opcodes of the interval set
package isil_pkg;

  localparam int unsigned MaxRangesDef = 64;
  localparam int unsigned PointBitsDef = 22;

  localparam int unsigned OpW    = 3;
  localparam int unsigned PortPW = 22;
  localparam int unsigned SelW   = 6;
  localparam int unsigned CountW = 7;

  localparam logic [OpW-1:0] OP_CLEAR   = 3'd0;
  localparam logic [OpW-1:0] OP_INSERT  = 3'd1;
  localparam logic [OpW-1:0] OP_LOOKUP  = 3'd2;
  localparam logic [OpW-1:0] OP_CONTAIN = 3'd3;
  localparam logic [OpW-1:0] OP_READ    = 3'd4;

  typedef struct packed {
    logic [OpW-1:0]    opcode;
    logic [PortPW-1:0] range_low;
    logic [PortPW-1:0] range_high;
    logic [PortPW-1:0] code_point;
    logic [SelW-1:0]   entry_select;
  } isil_req_t;

  typedef struct packed {
    logic              hit;
    logic [SelW-1:0]   found_index;
    logic [PortPW-1:0] entry_start;
    logic [PortPW-1:0] entry_stop;
    logic [CountW-1:0] range_count;
    logic              full_error;
  } isil_rsp_t;

endpackage

@@ src/interval_set_insert_lookup.sv @@
// top level: sorted interval set with merging insert, lookup, containment, read and clear
//
//   channel | direction | signals
//   request | in        | in_valid_i, in_ready_o, in_req_i
//   result  | out       | out_valid_o, out_ready_i, out_rsp_o
//
// one request at a time; in_ready_o is high only while the sequencer is idle.
// insert streams the n stored ranges through one merge unit, one element a cycle;
// lookup and containment scan one entry a cycle. results wait in an output register,
// so the next request is taken while a result is stalled. no clearing pass after reset.
module interval_set_insert_lookup
  import isil_pkg::*;
#(
  parameter int unsigned MaxRanges = MaxRangesDef,
  parameter int unsigned PointBits = PointBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  isil_req_t in_req_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output isil_rsp_t out_rsp_o
);

  localparam int unsigned AW = $clog2(MaxRanges);
  localparam int unsigned CW = $clog2(MaxRanges + 1);
  localparam int unsigned MW = $clog2(MaxRanges + 2);
  localparam int unsigned WW = (CW > SelW) ? CW : SelW;
  localparam int unsigned PW = PointBits;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]     state_q, state_d;
  logic [OpW-1:0] op_q, op_d;
  logic [PW-1:0]  key_a_q, key_a_d, key_b_q, key_b_d;
  logic           bank_q, bank_d;
  logic [CW-1:0]  used_q, used_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic           placed_q, placed_d;
  logic           cur_v_q, cur_v_d;
  logic [PW-1:0]  cur_s_q, cur_s_d, cur_e_q, cur_e_d;
  logic [MW-1:0]  wcnt_q, wcnt_d;
  isil_rsp_t      res_q, res_d;
  isil_rsp_t      out_q, out_d;
  logic           out_valid_q, out_valid_d;

  logic [2*PW-1:0] rdata0, rdata1, rdata;
  logic [PW-1:0]   rd_s, rd_e, elem_s, elem_e, in_lo, in_hi;
  logic            at_end, take_new, touch, wr_ok, we, in_acc, sel_ok, has_a, has_b;
  logic [MW-1:0]   total;

  isil_ram #(.Width(2 * PW), .Depth(MaxRanges)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (we && bank_q),
    .waddr_i (wcnt_q[AW-1:0]),
    .wdata_i ({cur_s_q, cur_e_q}),
    .raddr_i (idx_d[AW-1:0]),
    .rdata_o (rdata0)
  );

  isil_ram #(.Width(2 * PW), .Depth(MaxRanges)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (we && !bank_q),
    .waddr_i (wcnt_q[AW-1:0]),
    .wdata_i ({cur_s_q, cur_e_q}),
    .raddr_i (idx_d[AW-1:0]),
    .rdata_o (rdata1)
  );

  assign rdata = bank_q ? rdata1 : rdata0;
  assign rd_s  = rdata[2*PW-1:PW];
  assign rd_e  = rdata[PW-1:0];

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign in_lo  = PW'(in_req_i.range_low);
  assign in_hi  = PW'(in_req_i.range_high);
  assign sel_ok = WW'(in_req_i.entry_select) < WW'(used_q);

  // merge unit: pick the new range ahead of the first larger stored start
  assign at_end   = (idx_q == used_q);
  assign take_new = !placed_q && (at_end || key_a_q < rd_s);
  assign elem_s   = take_new ? key_a_q : rd_s;
  assign elem_e   = take_new ? key_b_q : rd_e;
  assign touch    = {1'b0, elem_s} <= ({1'b0, cur_e_q} + {{PW{1'b0}}, 1'b1});
  assign wr_ok    = wcnt_q < MW'(MaxRanges);
  assign total    = wcnt_q + MW'(1);
  assign has_a    = (rd_s <= key_a_q) && (key_a_q <= rd_e);
  assign has_b    = (rd_s <= key_b_q) && (key_b_q <= rd_e);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_a_d     = key_a_q;
    key_b_d     = key_b_q;
    bank_d      = bank_q;
    used_d      = used_q;
    idx_d       = idx_q;
    placed_d    = placed_q;
    cur_v_d     = cur_v_q;
    cur_s_d     = cur_s_q;
    cur_e_d     = cur_e_q;
    wcnt_d      = wcnt_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    we          = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d     = in_req_i.opcode;
          res_d    = '0;
          idx_d    = '0;
          placed_d = 1'b0;
          cur_v_d  = 1'b0;
          wcnt_d   = '0;
          state_d  = S_DONE;
          case (in_req_i.opcode)
            OP_CLEAR: begin
              used_d = '0;
            end
            OP_INSERT: begin
              key_a_d = (in_hi < in_lo) ? in_hi : in_lo;
              key_b_d = (in_hi < in_lo) ? in_lo : in_hi;
              state_d = S_INS;
            end
            OP_LOOKUP: begin
              key_a_d = PW'(in_req_i.code_point);
              state_d = S_SCAN;
            end
            OP_CONTAIN: begin
              key_a_d = in_lo;
              key_b_d = in_hi;
              state_d = S_SCAN;
            end
            OP_READ: begin
              if (sel_ok) begin
                idx_d             = CW'(in_req_i.entry_select);
                res_d.found_index = in_req_i.entry_select;
                state_d           = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_INS: begin
        if (placed_q && at_end) begin
          // flush the last merged range and commit by swapping banks, unless the set overflows
          we = wr_ok;
          if (total > MW'(MaxRanges)) begin
            res_d.full_error = 1'b1;
          end else begin
            bank_d = !bank_q;
            used_d = CW'(total);
          end
          state_d = S_DONE;
        end else begin
          if (!cur_v_q) begin
            cur_v_d = 1'b1;
            cur_s_d = elem_s;
            cur_e_d = elem_e;
          end else if (touch) begin
            if (cur_e_q < elem_e) begin
              cur_e_d = elem_e;
            end
          end else begin
            we      = wr_ok;
            wcnt_d  = total;
            cur_s_d = elem_s;
            cur_e_d = elem_e;
          end
          if (take_new) begin
            placed_d = 1'b1;
          end else begin
            idx_d = idx_q + CW'(1);
          end
        end
      end
      S_SCAN: begin
        if (at_end) begin
          state_d = S_DONE;
        end else if (has_a) begin
          // ranges are disjoint, so the entry holding the first key is unique
          if (op_q == OP_LOOKUP || has_b) begin
            res_d.hit         = 1'b1;
            res_d.found_index = SelW'(idx_q);
            res_d.entry_start = PortPW'(rd_s);
            res_d.entry_stop  = PortPW'(rd_e);
          end
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      S_READ: begin
        res_d.hit         = 1'b1;
        res_d.entry_start = PortPW'(rd_s);
        res_d.entry_stop  = PortPW'(rd_e);
        state_d           = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d             = res_q;
          out_d.range_count = CountW'(used_q);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bank_q      <= 1'b0;
      used_q      <= '0;
      idx_q       <= '0;
      placed_q    <= 1'b0;
      cur_v_q     <= 1'b0;
      wcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bank_q      <= bank_d;
      used_q      <= used_d;
      idx_q       <= idx_d;
      placed_q    <= placed_d;
      cur_v_q     <= cur_v_d;
      wcnt_q      <= wcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    key_a_q <= key_a_d;
    key_b_q <= key_b_d;
    cur_s_q <= cur_s_d;
    cur_e_q <= cur_e_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

endmodule

@@ src/isil_ram.sv @@
// generic single write, single read ram with registered read data
module isil_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ src/isil_checker.sv @@
// port checker for the interval set, bound to the top level
`include "interval_set_insert_lookup_assert.svh"

module isil_checker
  import isil_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input isil_req_t in_req_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input isil_rsp_t out_rsp_o
);

  // a stalled result keeps its value
  `ISIL_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))

  // the sequencer is busy in the cycle after taking a request
  `ISIL_ASSERT(a_busy_after_req, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)

  // a result without a hit carries no entry
  `ISIL_ASSERT(a_miss_zero, clk_i, rst_ni, out_valid_o && !out_rsp_o.hit |-> out_rsp_o.found_index == '0 && out_rsp_o.entry_start == '0 && out_rsp_o.entry_stop == '0)

  // an overflowing insert never reports a hit
  `ISIL_ASSERT(a_err_no_hit, clk_i, rst_ni, out_valid_o && out_rsp_o.full_error |-> !out_rsp_o.hit)

endmodule

bind interval_set_insert_lookup isil_checker u_isil_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
